// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge
`define ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the trigger
`define ASSERT_IMPL(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
    else $error(msg);

// consequent holds in the cycle after the trigger
`define ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`endif

// ----- design/htd_pkg.sv -----
// ----------------------------------------------------------------------------
// htd_pkg
// Field widths, command and result codes for the huffman tree decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int CMD_W           = 2;
  localparam int SYM_W           = 8;
  localparam int LEN_W           = 6;
  localparam int CODE_W          = 32;
  localparam int POS_W           = $clog2(CODE_W);
  localparam int KIND_W          = 2;
  localparam int MAX_CODE_LENGTH = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_DECODE = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SYMBOL  = 2'd0,
    KIND_MISSING = 2'd1,
    KIND_FULL    = 2'd2
  } kind_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [SYM_W-1:0] symbol;
  } result_t;

endpackage

// ----- design/htd_ram.sv -----
// ----------------------------------------------------------------------------
// htd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module htd_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 512,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/htd_seq.sv -----
// ----------------------------------------------------------------------------
// htd_seq
// Sequencer for tree load and bit decode; one node-table read and one child
// select per step, with node allocation against the fill count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htd_seq #(
  parameter int NODE_CAPACITY = 512,
  localparam int IDX_W   = $clog2(NODE_CAPACITY),
  localparam int CNT_W   = $clog2(NODE_CAPACITY + 1),
  localparam int ENTRY_W = 2 * IDX_W + htd_pkg::SYM_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [htd_pkg::CMD_W-1:0]   command,
  input  logic [htd_pkg::SYM_W-1:0]   entry_symbol,
  input  logic [htd_pkg::LEN_W-1:0]   code_length,
  input  logic [htd_pkg::CODE_W-1:0]  code_value,
  input  logic                        coded_bit,
  output logic                        busy,
  output htd_pkg::result_t            result,
  output logic                        ram_we,
  output logic [IDX_W-1:0]            ram_waddr,
  output logic [ENTRY_W-1:0]          ram_wdata,
  output logic [IDX_W-1:0]            ram_raddr,
  input  logic [ENTRY_W-1:0]          ram_rdata
);

  localparam int SYM_W = htd_pkg::SYM_W;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_D_CHILD,
    S_D_LEAF,
    S_L_STEP,
    S_L_LINK
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           used_r, used_nxt;
  logic [IDX_W-1:0]           walk_r, walk_nxt;
  logic [IDX_W-1:0]           cur_r, cur_nxt;
  logic [IDX_W-1:0]           next_r, next_nxt;
  logic [ENTRY_W-1:0]         link_r, link_nxt;
  logic [SYM_W-1:0]           sym_r, sym_nxt;
  logic [htd_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [htd_pkg::LEN_W-1:0]  pos_r, pos_nxt;
  logic                       bit_r, bit_nxt;
  logic                       last_r, last_nxt;

  logic [IDX_W-1:0] rd_left, rd_right, slot, fresh;
  logic [SYM_W-1:0] rd_sym;
  logic             code_bit, step_bit, last, len_bad;

  assign rd_left  = ram_rdata[ENTRY_W-1 -: IDX_W];
  assign rd_right = ram_rdata[SYM_W+IDX_W-1 -: IDX_W];
  assign rd_sym   = ram_rdata[SYM_W-1:0];

  // code bits above the register width read as zero
  assign code_bit = (pos_r < htd_pkg::LEN_W'(htd_pkg::CODE_W)) ?
                    code_r[pos_r[htd_pkg::POS_W-1:0]] : 1'b0;
  assign step_bit = (state_r == S_D_CHILD) ? bit_r : code_bit;
  assign slot     = step_bit ? rd_right : rd_left;
  assign last     = (pos_r == '0);
  assign fresh    = used_r[IDX_W-1:0];
  assign len_bad  = (code_length == '0) ||
                    ({1'b0, code_length} > 7'(htd_pkg::MAX_CODE_LENGTH));

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    walk_nxt  = walk_r;
    cur_nxt   = cur_r;
    next_nxt  = next_r;
    link_nxt  = link_r;
    sym_nxt   = sym_r;
    code_nxt  = code_r;
    pos_nxt   = pos_r;
    bit_nxt   = bit_r;
    last_nxt  = last_r;
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = '0;
    ram_raddr = cur_r;
    result    = '{valid: 1'b0, kind: htd_pkg::KIND_SYMBOL, symbol: '0};

    unique case (state_r)
      S_INIT: begin
        // root goes back to an empty node, the fill count hides the rest
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        used_nxt  = CNT_W'(1);
        walk_nxt  = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          sym_nxt  = entry_symbol;
          code_nxt = code_value;
          bit_nxt  = coded_bit;
          pos_nxt  = code_length - htd_pkg::LEN_W'(1);
          unique case (htd_pkg::cmd_t'(command))
            htd_pkg::CMD_CLEAR: begin
              state_nxt = S_INIT;
            end
            htd_pkg::CMD_LOAD: begin
              if (!len_bad) begin
                cur_nxt   = '0;
                ram_raddr = '0;
                state_nxt = S_L_STEP;
              end
            end
            htd_pkg::CMD_DECODE: begin
              ram_raddr = walk_r;
              state_nxt = S_D_CHILD;
            end
            default: begin
            end
          endcase
        end
      end
      S_D_CHILD: begin
        if (slot == '0) begin
          result    = '{valid: 1'b1, kind: htd_pkg::KIND_MISSING, symbol: '0};
          walk_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          next_nxt  = slot;
          ram_raddr = slot;
          state_nxt = S_D_LEAF;
        end
      end
      S_D_LEAF: begin
        if (rd_left == '0 && rd_right == '0) begin
          result   = '{valid: 1'b1, kind: htd_pkg::KIND_SYMBOL, symbol: rd_sym};
          walk_nxt = '0;
        end else begin
          walk_nxt = next_r;
        end
        state_nxt = S_IDLE;
      end
      S_L_STEP: begin
        if (last || slot == '0) begin
          if (used_r == CNT_W'(NODE_CAPACITY)) begin
            result    = '{valid: 1'b1, kind: htd_pkg::KIND_FULL, symbol: '0};
            state_nxt = S_IDLE;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = fresh;
            ram_wdata = {{(2 * IDX_W){1'b0}}, (last ? sym_r : {SYM_W{1'b0}})};
            link_nxt  = step_bit ? {rd_left, fresh, rd_sym} : {fresh, rd_right, rd_sym};
            next_nxt  = fresh;
            used_nxt  = used_r + CNT_W'(1);
            last_nxt  = last;
            state_nxt = S_L_LINK;
          end
        end else begin
          cur_nxt   = slot;
          pos_nxt   = pos_r - htd_pkg::LEN_W'(1);
          ram_raddr = slot;
        end
      end
      S_L_LINK: begin
        // hook the new node into its parent
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = link_r;
        if (last_r) begin
          state_nxt = S_IDLE;
        end else begin
          cur_nxt   = next_r;
          pos_nxt   = pos_r - htd_pkg::LEN_W'(1);
          ram_raddr = next_r;
          state_nxt = S_L_STEP;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      used_r  <= CNT_W'(1);
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      walk_r  <= walk_nxt;
    end
    cur_r  <= cur_nxt;
    next_r <= next_nxt;
    link_r <= link_nxt;
    sym_r  <= sym_nxt;
    code_r <= code_nxt;
    pos_r  <= pos_nxt;
    bit_r  <= bit_nxt;
    last_r <= last_nxt;
  end

  `ASSERT_HOLDS(a_used_range, (used_r >= CNT_W'(1)) && (used_r <= CNT_W'(NODE_CAPACITY)), "node count out of range")
  `ASSERT_HOLDS(a_walk_alloc, CNT_W'(walk_r) < used_r, "walk position points past allocated nodes")
  `ASSERT_NEXT(a_single_result, result.valid, !result.valid, "result produced on back-to-back cycles")
  `ASSERT_IMPL(a_idle_no_write, !busy, !ram_we, "node table written while idle")

endmodule

// ----- design/huffman_tree_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit
// Builds a binary decode tree in a node table and walks it one coded bit at a
// time. A command is taken when start is high and busy is low. A clear
// rewrites the root node and returns to idle. A decode reads the current
// node, then reads the selected child and reports a leaf's symbol or moves
// the walk on; a missing branch ends it after the first read. A load walks
// the existing nodes on the code's path and allocates a new node, then links
// it into its parent; when the table runs full the failing step ends the
// load. A load with a zero length or a length above the maximum, and the
// unused command, leave busy low. Each step uses the single read and single write port of the node table.
// After reset the block is busy for one cycle while the root node is written.
// A result appears on the out_ ports for exactly one cycle, flagged by
// out_valid, the cycle after the final step; the receiver cannot stall, so it
// must take the result then.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_tree_decoder_unit #(
  parameter int NODE_CAPACITY = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [htd_pkg::CMD_W-1:0]    in_command,
  input  logic [htd_pkg::SYM_W-1:0]    in_entry_symbol,
  input  logic [htd_pkg::LEN_W-1:0]    in_code_length,
  input  logic [htd_pkg::CODE_W-1:0]   in_code_value,
  input  logic                         in_coded_bit,
  output logic                         out_valid,
  output logic [htd_pkg::KIND_W-1:0]   out_result_kind,
  output logic [htd_pkg::SYM_W-1:0]    out_decoded_symbol
);

  localparam int IDX_W   = $clog2(NODE_CAPACITY);
  localparam int ENTRY_W = 2 * IDX_W + htd_pkg::SYM_W;

  logic                   accept;
  htd_pkg::result_t       result;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;

  logic                       out_valid_r;
  htd_pkg::kind_t             out_kind_r;
  logic [htd_pkg::SYM_W-1:0]  out_sym_r;
  logic                       err_result;

  assign accept = start && !busy;

  htd_seq #(
    .NODE_CAPACITY (NODE_CAPACITY)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .command      (in_command),
    .entry_symbol (in_entry_symbol),
    .code_length  (in_code_length),
    .code_value   (in_code_value),
    .coded_bit    (in_coded_bit),
    .busy         (busy),
    .result       (result),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  htd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_CAPACITY)
  ) u_node_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register, strobe lasts one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= result.valid;
    end
    out_kind_r <= result.kind;
    out_sym_r  <= result.symbol;
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_decoded_symbol = out_sym_r;

  assign err_result = out_valid_r && (out_kind_r != htd_pkg::KIND_SYMBOL);

  `ASSERT_IMPL(a_out_after_busy, out_valid_r, $past(busy), "strobe without a command")
  `ASSERT_IMPL(a_out_sym_zero, err_result, out_sym_r == '0, "error result with a symbol")

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives clear, load and decode commands into the huffman tree decoder and
// checks every decoded symbol, missing branch and table full flag against a
// behavioral copy of the node table kept in the bench. Stimulus covers
// prefix code sets decoded end to end, corrupted streams, overlapping codes,
// random noise and table exhaustion, under several sender idle rates.
// ----------------------------------------------------------------------------
module tb;

  localparam int NODE_CAPACITY   = 512;
  localparam int CMD_W           = htd_pkg::CMD_W;
  localparam int SYM_W           = htd_pkg::SYM_W;
  localparam int LEN_W           = htd_pkg::LEN_W;
  localparam int CODE_W          = htd_pkg::CODE_W;
  localparam int KIND_W          = htd_pkg::KIND_W;
  localparam int MAX_CODE_LENGTH = htd_pkg::MAX_CODE_LENGTH;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  length;
    logic [CODE_W-1:0] code;
    logic              coded_bit;
  } tree_cmd_t;

  typedef struct {
    htd_pkg::kind_t   kind;
    logic [SYM_W-1:0] symbol;
  } tree_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [CMD_W-1:0]  in_command = htd_pkg::CMD_CLEAR;
  logic [SYM_W-1:0]  in_entry_symbol = '0;
  logic [LEN_W-1:0]  in_code_length = '0;
  logic [CODE_W-1:0] in_code_value = '0;
  logic              in_coded_bit = 1'b0;
  logic busy;
  logic out_valid;
  logic [KIND_W-1:0] out_result_kind;
  logic [SYM_W-1:0]  out_decoded_symbol;

  huffman_tree_decoder_unit #(.NODE_CAPACITY(NODE_CAPACITY)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_entry_symbol    (in_entry_symbol),
    .in_code_length     (in_code_length),
    .in_code_value      (in_code_value),
    .in_coded_bit       (in_coded_bit),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_decoded_symbol (out_decoded_symbol)
  );

  always #4 clk = ~clk;

  tree_cmd_t    pending_q[$];
  tree_result_t expected_q[$];
  tree_cmd_t    cur_cmd;
  int           idle_pct = 0;
  int           live_items = 0;
  int           mismatch_count = 0;

  // node table copy
  int unsigned      left_ch  [NODE_CAPACITY];
  int unsigned      right_ch [NODE_CAPACITY];
  logic [SYM_W-1:0] leaf_sym [NODE_CAPACITY];
  int unsigned      nodes_used;
  int unsigned      walk_node;

  // current prefix code set
  int               cw_len[$];
  logic [31:0]      cw_val[$];
  logic [SYM_W-1:0] cw_sym[$];

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void tree_clear();
    for (int n = 0; n < NODE_CAPACITY; n++) begin
      left_ch[n] = 0;
      right_ch[n] = 0;
      leaf_sym[n] = '0;
    end
    nodes_used = 1;
    walk_node = 0;
  endfunction

  // advance the tree copy by one command, queue the result it causes
  function automatic void tree_step(input tree_cmd_t c);
    int unsigned  cur;
    int unsigned  nxt;
    int           len;
    logic         b;
    logic         last;
    logic         full;
    tree_result_t r;
    len = int'(c.length);
    full = 1'b0;
    case (c.command)
      htd_pkg::CMD_CLEAR: tree_clear();
      htd_pkg::CMD_LOAD: begin
        if (len != 0 && len <= MAX_CODE_LENGTH) begin
          cur = 0;
          for (int j = 0; j < len && !full; j++) begin
            b = c.code[len-1-j];
            last = (j + 1 == len);
            nxt = b ? right_ch[cur] : left_ch[cur];
            if (last || nxt == 0) begin
              if (nodes_used >= NODE_CAPACITY) begin
                full = 1'b1;
              end else begin
                nxt = nodes_used;
                nodes_used++;
                left_ch[nxt] = 0;
                right_ch[nxt] = 0;
                leaf_sym[nxt] = last ? c.symbol : '0;
                if (b) right_ch[cur] = nxt;
                else left_ch[cur] = nxt;
              end
            end
            cur = nxt;
          end
          if (full) begin
            r.kind = htd_pkg::KIND_FULL;
            r.symbol = '0;
            expected_q.push_back(r);
          end
        end
      end
      htd_pkg::CMD_DECODE: begin
        nxt = c.coded_bit ? right_ch[walk_node] : left_ch[walk_node];
        if (nxt == 0) begin
          walk_node = 0;
          r.kind = htd_pkg::KIND_MISSING;
          r.symbol = '0;
          expected_q.push_back(r);
        end else if (left_ch[nxt] == 0 && right_ch[nxt] == 0) begin
          walk_node = 0;
          r.kind = htd_pkg::KIND_SYMBOL;
          r.symbol = leaf_sym[nxt];
          expected_q.push_back(r);
        end else begin
          walk_node = nxt;
        end
      end
      default: ;
    endcase
  endfunction

  // driver: hold while busy, otherwise maybe take the next pending command
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) tree_step(cur_cmd);
      if (!(start && busy)) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_cmd = pending_q.pop_front();
          in_command      <= cur_cmd.command;
          in_entry_symbol <= cur_cmd.symbol;
          in_code_length  <= cur_cmd.length;
          in_code_value   <= cur_cmd.code;
          in_coded_bit    <= cur_cmd.coded_bit;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result is a transfer
  always @(posedge clk) begin : mon_blk
    tree_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d symbol %02h",
                                  out_result_kind, out_decoded_symbol));
      end else begin
        want = expected_q.pop_front();
        if (out_result_kind !== want.kind)
          report_mismatch($sformatf("result kind %0d, want %0d",
                                    out_result_kind, want.kind));
        if (out_decoded_symbol !== want.symbol)
          report_mismatch($sformatf("decoded symbol %02h, want %02h",
                                    out_decoded_symbol, want.symbol));
      end
    end
  end

  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                           input logic cbit);
    tree_cmd_t c;
    c.command = cmd;
    c.symbol = sym;
    c.length = len;
    c.code = code;
    c.coded_bit = cbit;
    pending_q.push_back(c);
    if (!(cmd == CMD_UNUSED ||
          (cmd == htd_pkg::CMD_LOAD && (len == 0 || len > MAX_CODE_LENGTH))))
      live_items++;
  endtask

  task automatic push_clear();
    push_item(htd_pkg::CMD_CLEAR, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(63)),
              $urandom, 1'($urandom_range(1)));
  endtask

  task automatic push_load(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                           input logic [CODE_W-1:0] code);
    push_item(htd_pkg::CMD_LOAD, sym, len, code, 1'($urandom_range(1)));
  endtask

  task automatic push_decode(input logic cbit);
    push_item(htd_pkg::CMD_DECODE, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(63)),
              $urandom, cbit);
  endtask

  // random full binary tree; in chain mode one branch keeps getting split
  task automatic build_code_set(input int leaves, input bit chain, input int max_len);
    int idx;
    int deep;
    int tries;
    int l;
    logic [31:0] v;
    cw_len.delete();
    cw_val.delete();
    cw_sym.delete();
    cw_len.push_back(0);
    cw_val.push_back(32'd0);
    deep = 0;
    tries = 0;
    while (cw_len.size() < leaves && tries < 400) begin
      tries++;
      idx = chain ? deep : $urandom_range(cw_len.size() - 1);
      if (cw_len[idx] < max_len) begin
        l = cw_len[idx];
        v = cw_val[idx];
        cw_len[idx] = l + 1;
        cw_val[idx] = v << 1;
        cw_len.push_back(l + 1);
        cw_val.push_back((v << 1) | 32'd1);
        deep = $urandom_range(1) ? idx : cw_len.size() - 1;
      end
    end
    foreach (cw_len[k]) cw_sym.push_back(SYM_W'($urandom_range(255)));
  endtask

  task automatic random_phase(input int quota);
    int goal;
    int sel;
    int k;
    int n;
    int leaves;
    bit chain;
    bit broken;
    logic [31:0] first_code;
    goal = live_items + quota;
    while (live_items < goal) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        // well-formed code set, loaded then decoded; some corrupted
        broken = (sel >= 65);
        if ($urandom_range(99) < 85) push_clear();
        chain = ($urandom_range(5) == 0);
        leaves = chain ? $urandom_range(2, 33) : $urandom_range(2, 16);
        build_code_set(leaves, chain, chain ? MAX_CODE_LENGTH : $urandom_range(4, 12));
        foreach (cw_len[i]) push_load(cw_sym[i], LEN_W'(cw_len[i]), cw_val[i]);
        if (broken) begin
          k = $urandom_range(cw_len.size() - 1);
          if (cw_len[k] > 1 && $urandom_range(1)) begin
            // prefix of an existing code replaces its subtree
            n = $urandom_range(1, cw_len[k] - 1);
            push_load(SYM_W'($urandom_range(255)), LEN_W'(n), cw_val[k] >> (cw_len[k] - n));
          end else begin
            // extension walks through an existing leaf
            n = cw_len[k] + $urandom_range(1, 4);
            if (n > MAX_CODE_LENGTH) n = MAX_CODE_LENGTH;
            push_load(SYM_W'($urandom_range(255)), LEN_W'(n),
                      (cw_val[k] << (n - cw_len[k])) |
                      ($urandom & ((32'd1 << (n - cw_len[k])) - 32'd1)));
          end
        end
        repeat (chain ? $urandom_range(2, 8) : $urandom_range(4, 24)) begin
          k = $urandom_range(cw_len.size() - 1);
          for (int b = cw_len[k] - 1; b >= 0; b--)
            push_decode(cw_val[k][b] ^ (broken && $urandom_range(19) == 0));
        end
      end else if (sel < 94) begin
        // noise
        repeat ($urandom_range(4, 20)) begin
          n = $urandom_range(9);
          if (n == 0) push_clear();
          else if (n <= 4)
            push_load(SYM_W'($urandom_range(255)),
                      LEN_W'(($urandom_range(3) == 0) ? $urandom_range(0, 63) :
                                                        $urandom_range(1, 6)),
                      $urandom);
          else if (n <= 8) push_decode(1'($urandom_range(1)));
          else push_item(CMD_UNUSED, SYM_W'($urandom_range(255)),
                         LEN_W'($urandom_range(63)), $urandom, 1'($urandom_range(1)));
        end
      end else begin
        // exhaust the node table with long codes of distinct prefixes
        push_clear();
        first_code = {5'd0, 27'($urandom)};
        push_load(SYM_W'($urandom_range(255)), LEN_W'(MAX_CODE_LENGTH), first_code);
        for (k = 1; k < 20; k++)
          push_load(SYM_W'($urandom_range(255)), LEN_W'(MAX_CODE_LENGTH),
                    {k[4:0], 27'($urandom)});
        repeat (3)
          push_load(SYM_W'($urandom_range(255)), LEN_W'($urandom_range(1, 8)), $urandom);
        for (int b = 31; b >= 0; b--) push_decode(first_code[b]);
      end
    end
  endtask

  task automatic drain_pending();
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    tree_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: bare root, ignored commands, leaf walk-through, replaced subtree
    idle_pct = 0;
    push_decode(1'b0);
    push_decode(1'b1);
    push_item(CMD_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b1);
    push_load(8'h11, 6'd0, 32'h0000_0001);
    push_load(8'h22, 6'd33, 32'h0000_0001);
    push_load(8'h33, 6'd63, 32'hFFFF_FFFF);
    push_load(8'hFF, 6'd1, 32'h0000_0001);
    push_load(8'h00, 6'd2, 32'h0000_0001);
    push_decode(1'b1);
    push_decode(1'b0);
    push_decode(1'b0);
    push_decode(1'b0);
    push_decode(1'b1);
    push_load(8'h3C, 6'd3, 32'h0000_0007);
    push_decode(1'b1);
    push_decode(1'b1);
    push_decode(1'b1);
    push_load(8'h81, 6'd1, 32'h0000_0001);
    push_decode(1'b1);
    push_load(8'h5A, 6'd32, 32'h8000_0000);
    push_load(8'h00, 6'd32, 32'hFFFF_FFFF);
    push_clear();
    push_decode(1'b0);
    drain_pending();

    random_phase(412);
    drain_pending();
    idle_pct = 59;
    random_phase(412);
    drain_pending();
    idle_pct = 33;
    random_phase(412);
    drain_pending();
    idle_pct = 0;
    random_phase(412);

    while (pending_q.size() != 0 || start || busy || expected_q.size() != 0)
      @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
